// ===== src/dsb_pkg.sv =====
// Shared types, constants and functions for the decimal seven-segment blanking core.
`default_nettype none
package dsb_pkg;

  localparam int VALUE_W  = 20;
  localparam int DIGITS   = 6;
  localparam int BCD_W    = 4 * DIGITS;
  localparam int SEG_W    = 8;
  localparam int LOWER_W  = 32;
  localparam int UPPER_W  = 16;

  localparam logic [VALUE_W-1:0] MAX_DISPLAY     = 20'd999999;
  localparam logic [VALUE_W-1:0] UPPER_THRESHOLD = 20'd9999;

  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
    logic               upper;
    logic               oor;
  } item_t;

  // Add 3 to every BCD nibble that is 5 or more, ahead of the next shift.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  // Active-high segments, gfedcba in bits 6:0.
  function automatic logic [SEG_W-1:0] seg_lookup(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== src/dsb_dabble_cell.sv =====
// One shift-add-3 cell: folds one binary bit into the BCD digits per transfer.
`default_nettype none
module dsb_dabble_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  input  wire dsb_pkg::item_t up_data,
  output logic               up_ready,
  output logic               dn_valid,
  output dsb_pkg::item_t     dn_data,
  input  wire logic          dn_ready
);

  logic           valid_r, valid_nxt;
  dsb_pkg::item_t data_r, data_nxt;
  logic [dsb_pkg::BCD_W-1:0] adj;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    adj                = dsb_pkg::bcd_adjust(up_data.bcd);
    data_nxt           = up_data;
    data_nxt.bcd       = {adj[dsb_pkg::BCD_W-2:0], up_data.bin[dsb_pkg::VALUE_W-1]};
    data_nxt.bin       = {up_data.bin[dsb_pkg::VALUE_W-2:0], 1'b0};
    valid_nxt          = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
`default_nettype wire

// ===== src/dsb_seg_cell.sv =====
// Final cell: blanking, segment mapping and the output register.
`default_nettype none
module dsb_seg_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_valid,
  input  wire dsb_pkg::item_t                up_data,
  output logic                               up_ready,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dsb_pkg::LOWER_W-1:0]        out_lower_segments,
  output logic [dsb_pkg::UPPER_W-1:0]        out_upper_segments,
  output logic                               out_upper_written,
  output logic                               out_out_of_range
);

  logic                        valid_r, valid_nxt;
  logic [dsb_pkg::LOWER_W-1:0] lower_r, lower_nxt;
  logic [dsb_pkg::UPPER_W-1:0] upper_r, upper_nxt;
  logic                        wr_r, wr_nxt;
  logic                        oor_r, oor_nxt;
  logic [dsb_pkg::DIGITS-1:0]  shown;
  logic [dsb_pkg::SEG_W*dsb_pkg::DIGITS-1:0] segs;

  assign up_ready = !valid_r || !out_stall;

  always_comb begin
    // shown[i]: digit i or a higher one is nonzero; units always shown
    shown[dsb_pkg::DIGITS-1] = (up_data.bcd[4*(dsb_pkg::DIGITS-1) +: 4] != 4'd0);
    for (int i = dsb_pkg::DIGITS-2; i >= 0; i--) begin
      shown[i] = shown[i+1] || (up_data.bcd[4*i +: 4] != 4'd0) || (i == 0);
    end
    for (int i = 0; i < dsb_pkg::DIGITS; i++) begin
      segs[dsb_pkg::SEG_W*i +: dsb_pkg::SEG_W] =
        shown[i] ? dsb_pkg::seg_lookup(up_data.bcd[4*i +: 4]) : '0;
    end
    if (up_data.oor) begin
      lower_nxt = '0;
      upper_nxt = '0;
      wr_nxt    = 1'b0;
    end else begin
      lower_nxt = segs[dsb_pkg::LOWER_W-1:0];
      upper_nxt = segs[dsb_pkg::LOWER_W +: dsb_pkg::UPPER_W];
      wr_nxt    = up_data.upper;
    end
    oor_nxt   = up_data.oor;
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
      wr_r    <= wr_nxt;
      oor_r   <= oor_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_lower_segments = lower_r;
  assign out_upper_segments = upper_r;
  assign out_upper_written  = wr_r;
  assign out_out_of_range   = oor_r;

endmodule
`default_nettype wire

// ===== src/decimal_seven_segment_blanking_core.sv =====
// Top level: binary-to-BCD cell row feeding the seven-segment blanking cell.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_value[19:0]
//   out_     output     out_valid / out_stall out_lower_segments, out_upper_segments,
//                                             out_upper_written, out_out_of_range
//
// One transfer per cycle sustained while out_stall is low. The pipeline is 20 shift-add-3
// cells (one per value bit) plus the segment/output register cell.
// Each cell carries a valid bit; a cell loads when it is empty or its
// neighbor takes its item, so empty slots absorb stalls and the input keeps
// accepting while a finished result waits at the output, until every cell is full.
// Reset (rst_n low, synchronous) empties every cell; payload is not reset.
`default_nettype none
module decimal_seven_segment_blanking_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [dsb_pkg::VALUE_W-1:0]   in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dsb_pkg::LOWER_W-1:0]        out_lower_segments,
  output logic [dsb_pkg::UPPER_W-1:0]        out_upper_segments,
  output logic                               out_upper_written,
  output logic                               out_out_of_range
);

  // stage k is the handoff into cell k; the last stage feeds the segment cell
  logic           stg_valid [0:dsb_pkg::VALUE_W];
  logic           stg_ready [0:dsb_pkg::VALUE_W];
  dsb_pkg::item_t stg_data  [0:dsb_pkg::VALUE_W];
  dsb_pkg::item_t in_item;

  // Range flags are settled up front and ride along with the digits.
  always_comb begin
    in_item.bcd   = '0;
    in_item.bin   = in_value;
    in_item.upper = (in_value > dsb_pkg::UPPER_THRESHOLD);
    in_item.oor   = (in_value > dsb_pkg::MAX_DISPLAY);
  end

  assign stg_data[0]  = in_item;
  assign stg_valid[0] = in_valid;
  assign in_stall     = !stg_ready[0];

  for (genvar k = 0; k < dsb_pkg::VALUE_W; k++) begin : g_cell
    dsb_dabble_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[k]),
      .up_data  (stg_data[k]),
      .up_ready (stg_ready[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_data  (stg_data[k+1]),
      .dn_ready (stg_ready[k+1])
    );
  end

  // Blanking and segment encode, output register.
  dsb_seg_cell u_seg (
    .clk                (clk),
    .rst_n              (rst_n),
    .up_valid           (stg_valid[dsb_pkg::VALUE_W]),
    .up_data            (stg_data[dsb_pkg::VALUE_W]),
    .up_ready           (stg_ready[dsb_pkg::VALUE_W]),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_lower_segments (out_lower_segments),
    .out_upper_segments (out_upper_segments),
    .out_upper_written  (out_upper_written),
    .out_out_of_range   (out_out_of_range)
  );

endmodule
`default_nettype wire

// ===== src/dsb_checker.sv =====
// Port-level checks for the decimal seven-segment blanking core, with bind.
`default_nettype none
module dsb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_lower_segments,
  input wire logic [15:0] out_upper_segments,
  input wire logic        out_upper_written,
  input wire logic        out_out_of_range
);

  // Out-of-range results carry nothing to write.
  a_oor_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |->
      out_lower_segments == 32'd0 && out_upper_segments == 16'd0 && !out_upper_written)
    else $error("out-of-range result not blank");

  // Units digit always lit for a displayable value.
  a_units_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |-> out_lower_segments[7:0] != 8'd0)
    else $error("units digit blanked");

  // Upper word blank unless flagged for writing.
  a_upper_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_upper_written |-> out_upper_segments == 16'd0)
    else $error("upper digits lit without write flag");

  // Decimal point bits never set.
  a_dp_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_lower_segments[31] && !out_lower_segments[23] &&
                  !out_lower_segments[15] && !out_lower_segments[7] &&
                  !out_upper_segments[15] && !out_upper_segments[7])
    else $error("segment bit 7 set");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_lower_segments) &&
                               $stable(out_upper_segments))
    else $error("stalled result changed");

endmodule

bind decimal_seven_segment_blanking_core dsb_checker u_dsb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_lower_segments (out_lower_segments),
  .out_upper_segments (out_upper_segments),
  .out_upper_written  (out_upper_written),
  .out_out_of_range   (out_out_of_range)
);
`default_nettype wire
